// ----- rtl/core/mrut_pkg.sv -----
// shared types and codes of the multi-resource usage tracker
// no dependencies; imported by every module of the tracker
`default_nettype none

package mrut_pkg;

  localparam int MAX_TYPES = 4;
  localparam int USAGE_W   = 31;
  localparam int AMOUNT_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 31;

  localparam logic [2:0] ACT_CHECK   = 3'd0;
  localparam logic [2:0] ACT_USE     = 3'd1;
  localparam logic [2:0] ACT_RELEASE = 3'd2;
  localparam logic [2:0] ACT_ADJUST  = 3'd3;
  localparam logic [2:0] ACT_SET     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CAP0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK = 3'd4;

  typedef struct packed {
    logic [2:0]                 action;
    logic [1:0]                 type_index;
    logic signed [AMOUNT_W-1:0] amount;
    logic                       last;
  } req_t;

  typedef struct packed {
    logic [1:0]         type_out;
    logic [USAGE_W-1:0] usage_now;
    logic [USAGE_W-1:0] available;
    logic               over_capacity;
    logic               status_ok;
    logic               last_out;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic calc;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_stall;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/mrut_ctrl.sv -----
// sequencer of the tracker: accept, compute, report
// depends on mrut_pkg for the command and status structs
`default_nettype none

module mrut_ctrl
  import mrut_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        // wait until the response register is free
        if (!sts.rsp_stall) begin
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/mrut_datapath.sv -----
// usage store, capacity registers, update arithmetic and response register
// depends on mrut_pkg for payload structs, action and register codes
`default_nettype none

module mrut_datapath
  import mrut_pkg::*;
#(
  parameter int NUM_TYPES = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire req_t                 req,
  input  wire ctrl_cmd_t            cmd,
  output ctrl_sts_t                 sts,
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output rsp_t                      rsp
);

  localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int EXT_W = AMOUNT_W + 2;

  logic [USAGE_W-1:0] usage_store [NUM_TYPES];
  logic [USAGE_W-1:0] capacity    [NUM_TYPES];
  logic [MAX_TYPES-1:0] ovf_mask;
  logic               running_ok;
  logic               check_fail;
  logic               release_fail;
  req_t               req_q;

  logic             type_ok;
  logic [IDX_W-1:0] tidx;
  logic signed [EXT_W-1:0] use_ext, cap_ext, amt_ext;
  logic signed [EXT_W-1:0] sum, diff, headroom, v;
  logic [USAGE_W-1:0] v_clamped;
  logic               writes_usage;
  logic               load_test;
  logic               check_fail_next, release_fail_next;

  logic [USAGE_W-1:0] u_now, c_now;
  logic               over, ok_new;

  assign type_ok = {1'b0, req_q.type_index} < 3'(NUM_TYPES);
  assign tidx    = req_q.type_index[IDX_W-1:0];

  // compute step: new usage and the check / release failures
  always_comb begin
    use_ext  = $signed({{(EXT_W-USAGE_W){1'b0}}, usage_store[tidx]});
    cap_ext  = $signed({{(EXT_W-USAGE_W){1'b0}}, capacity[tidx]});
    amt_ext  = $signed({{(EXT_W-AMOUNT_W){req_q.amount[AMOUNT_W-1]}}, req_q.amount});
    sum      = use_ext + amt_ext;
    diff     = use_ext - amt_ext;
    headroom = cap_ext - use_ext;
    writes_usage = 1'b0;
    case (req_q.action)
      ACT_USE, ACT_ADJUST: begin
        v = sum;
        writes_usage = 1'b1;
      end
      ACT_RELEASE: begin
        v = diff;
        writes_usage = 1'b1;
      end
      ACT_SET: begin
        v = amt_ext;
        writes_usage = 1'b1;
      end
      default: begin
        v = use_ext;
      end
    endcase
    // clamp to the usage range
    if (v[EXT_W-1]) begin
      v_clamped = '0;
    end else if (v[EXT_W-2:USAGE_W] != '0) begin
      v_clamped = '1;
    end else begin
      v_clamped = v[USAGE_W-1:0];
    end
    check_fail_next   = type_ok && (req_q.action == ACT_CHECK) &&
                        !ovf_mask[req_q.type_index] && (amt_ext > headroom);
    release_fail_next = type_ok && (req_q.action == ACT_RELEASE) && diff[EXT_W-1];
  end

  // report step: figures from the updated usage
  always_comb begin
    u_now     = usage_store[tidx];
    c_now     = capacity[tidx];
    over      = u_now > c_now;
    load_test = (req_q.action == ACT_USE) || (req_q.action == ACT_ADJUST) ||
                (req_q.action == ACT_SET);
    ok_new    = running_ok &&
                !(check_fail || release_fail || (type_ok && load_test && over));
  end

  assign sts.rsp_stall = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TYPES; i++) begin
        usage_store[i] <= '0;
        capacity[i]    <= '0;
      end
      ovf_mask   <= '0;
      running_ok <= 1'b1;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MASK) begin
          ovf_mask <= cfg_data[MAX_TYPES-1:0];
        end else if (cfg_index - REG_CAP0 < 3'(NUM_TYPES)) begin
          capacity[cfg_index[IDX_W-1:0]] <= cfg_data[USAGE_W-1:0];
        end
      end
      if (cmd.calc && type_ok && writes_usage) begin
        usage_store[tidx] <= v_clamped;
      end
      if (cmd.report) begin
        running_ok <= req_q.last ? 1'b1 : ok_new;
        rsp_valid  <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
    end
    if (cmd.calc) begin
      check_fail   <= check_fail_next;
      release_fail <= release_fail_next;
    end
    if (cmd.report) begin
      rsp.type_out      <= req_q.type_index;
      rsp.usage_now     <= type_ok ? u_now : '0;
      rsp.available     <= (type_ok && (c_now > u_now)) ? (c_now - u_now) : '0;
      rsp.over_capacity <= type_ok && over;
      rsp.status_ok     <= ok_new;
      rsp.last_out      <= req_q.last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/multi_resource_usage_tracker_top.sv -----
// multi-resource usage tracker: the accept, compute, report sequencer takes a transfer
// in idle, then computes and reports it before it takes the next item; the response
// register frees the input side, so the next item transfers while a response waits
// synchronous active-high reset: usage and capacities zero, overflow mask zero,
// running status one, no response pending
// depends on mrut_pkg, mrut_ctrl and mrut_datapath
`default_nettype none

module multi_resource_usage_tracker_top
  import mrut_pkg::*;
#(
  parameter int NUM_TYPES = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration writes, to be made only while the tracker is idle; the block does not enforce it
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  // request channel, one item per resource type, last closes a request
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire req_t                 req,
  // response channel, one result per request item
  output logic                      rsp_valid,
  input  wire logic                 rsp_ready,
  output rsp_t                      rsp
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: idle takes the transfer, then a compute state and a report state that waits for the response register
  mrut_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // register file, clamp arithmetic, running status and response register
  mrut_datapath #(
    .NUM_TYPES (NUM_TYPES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- dv/mrut_usage_checker.sv -----
`timescale 1ns / 1ps
// in-order response checker for the multi-resource usage tracker: mirrors capacities,
// usage and running status, predicts one response per request transfer; uses mrut_pkg
module mrut_usage_checker
  import mrut_pkg::*;
#(
  parameter int NUM_TYPES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  req_t                 req,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  rsp_t                 rsp,
  output int                   errors,
  output int                   outstanding
);

  localparam logic [USAGE_W-1:0] USAGE_TOP   = {USAGE_W{1'b1}};
  localparam longint             USAGE_TOP_L = 64'sh7FFF_FFFF;

  logic [USAGE_W-1:0]   cap_mirror   [MAX_TYPES];
  logic [USAGE_W-1:0]   usage_mirror [MAX_TYPES];
  logic [MAX_TYPES-1:0] ovf_mask;
  logic                 run_ok;
  rsp_t                 rsp_due_q [$];
  int                   err_cnt = 0;

  function automatic logic [USAGE_W-1:0] sat_usage(input longint v);
    if (v < 0) return '0;
    if (v > USAGE_TOP_L) return USAGE_TOP;
    return v[USAGE_W-1:0];
  endfunction

  // one request item against the mirrored state; updates usage and status
  function automatic rsp_t predict_rsp(input req_t item);
    rsp_t   r;
    longint used;
    longint cap;
    longint amt;
    longint diff;
    int     t;
    r = '0;
    t = int'(item.type_index);
    r.type_out = item.type_index;
    r.last_out = item.last;
    if (t < NUM_TYPES) begin
      used = longint'(usage_mirror[t]);
      cap  = longint'(cap_mirror[t]);
      amt  = longint'($signed(item.amount));
      case (item.action)
        ACT_CHECK: begin
          if (!ovf_mask[t] && amt > cap - used) run_ok = 1'b0;
        end
        ACT_USE, ACT_ADJUST: begin
          usage_mirror[t] = sat_usage(used + amt);
          if (usage_mirror[t] > cap_mirror[t]) run_ok = 1'b0;
        end
        ACT_RELEASE: begin
          diff = used - amt;
          if (diff < 0) run_ok = 1'b0;
          usage_mirror[t] = sat_usage(diff);
        end
        ACT_SET: begin
          usage_mirror[t] = sat_usage(amt);
          if (usage_mirror[t] > cap_mirror[t]) run_ok = 1'b0;
        end
        default: begin
          // undefined action leaves everything as it is
        end
      endcase
      r.usage_now     = usage_mirror[t];
      r.available     = (cap_mirror[t] > usage_mirror[t]) ?
                        cap_mirror[t] - usage_mirror[t] : '0;
      r.over_capacity = usage_mirror[t] > cap_mirror[t];
    end
    r.status_ok = run_ok;
    if (item.last) run_ok = 1'b1;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: rsp.%s mismatch, expected %0h actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < MAX_TYPES; i++) begin
        cap_mirror[i]   = '0;
        usage_mirror[i] = '0;
      end
      ovf_mask = '0;
      run_ok   = 1'b1;
      rsp_due_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index < REG_MASK) cap_mirror[cfg_index[1:0]] = cfg_data;
        else if (cfg_index == REG_MASK) ovf_mask = cfg_data[MAX_TYPES-1:0];
      end
      if (rsp_valid && rsp_ready) begin
        if (rsp_due_q.size() == 0) begin
          $display("%0t: unexpected response, expected none actual %0h", $time, rsp);
          err_cnt++;
        end else begin
          want = rsp_due_q.pop_front();
          check_field("type_out", 32'(want.type_out), 32'(rsp.type_out));
          check_field("usage_now", 32'(want.usage_now), 32'(rsp.usage_now));
          check_field("available", 32'(want.available), 32'(rsp.available));
          check_field("over_capacity", 32'(want.over_capacity), 32'(rsp.over_capacity));
          check_field("status_ok", 32'(want.status_ok), 32'(rsp.status_ok));
          check_field("last_out", 32'(want.last_out), 32'(rsp.last_out));
        end
      end
      if (req_valid && req_ready) rsp_due_q.push_back(predict_rsp(req));
    end
    errors      <= err_cnt;
    outstanding <= rsp_due_q.size();
  end

endmodule

// ----- dv/tb_multi_resource_usage_tracker_top.sv -----
`timescale 1ns / 1ps
// testbench top for the multi-resource usage tracker: clock, reset, configuration,
// request stimulus and response back-pressure; uses mrut_pkg and mrut_usage_checker
module tb_multi_resource_usage_tracker_top;
  import mrut_pkg::*;

  localparam int NUM_TYPES    = 4;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 7;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 req_valid;
  logic                 req_ready;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_ready;
  rsp_t                 rsp;
  int                   errors;
  int                   outstanding;

  // idling: 0 means none, otherwise a burst starts with one chance in idle_odds
  int                   idle_odds = 0;
  int                   items_sent = 0;
  // capacities of the current setting, also used to aim demands near the limits
  logic [CFG_DAT_W-1:0] cap_plan [MAX_TYPES];

  multi_resource_usage_tracker_top #(
    .NUM_TYPES (NUM_TYPES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  mrut_usage_checker #(
    .NUM_TYPES (NUM_TYPES)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("** multi_resource_usage_tracker_top: FAILED **");
    $finish;
  end

  // response side: random stall bursts while idling is on
  initial begin
    rsp_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // all four capacities from cap_plan, then the overflow mask; only while idle
  task automatic load_config(input logic [MAX_TYPES-1:0] mask);
    for (int i = 0; i < MAX_TYPES; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_CAP0 + CFG_IDX_W'(i);
      cfg_data  <= cap_plan[i];
      @(posedge clk);
    end
    cfg_index <= REG_MASK;
    cfg_data  <= CFG_DAT_W'(mask);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one request transfer, with an optional gap in front; valid stays up afterwards
  task automatic send(input logic [2:0] act, input logic [1:0] t,
                      input logic [AMOUNT_W-1:0] amt, input logic lst);
    req_t item;
    item.action     = act;
    item.type_index = t;
    item.amount     = amt;
    item.last       = lst;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop sending and wait until every response has been taken
  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // demand mix: extremes, small negatives, full random, and values around the capacity
  function automatic logic [AMOUNT_W-1:0] pick_amount(input logic [1:0] t);
    int unsigned hi;
    hi = cap_plan[t] + (cap_plan[t] >> 2) + 8;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'd0 - $urandom_range(0, 40);
      4: return 32'd0;
      5: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // well-formed request: distinct types in random order, one action unless mixed
  task automatic send_request;
    logic [1:0] order [MAX_TYPES];
    logic [1:0] tmp;
    logic [2:0] act;
    int         j;
    int         n;
    bit         mixed;
    for (int i = 0; i < NUM_TYPES; i++) order[i] = 2'(i);
    for (int i = NUM_TYPES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    n     = $urandom_range(1, NUM_TYPES);
    mixed = ($urandom_range(0, 4) == 0);
    act   = 3'($urandom_range(ACT_CHECK, ACT_SET));
    for (int i = 0; i < n; i++) begin
      if (mixed) act = 3'($urandom_range(ACT_CHECK, ACT_SET));
      send(act, order[i], pick_amount(order[i]), i == n - 1);
    end
  endtask

  // stray item: any action code, any type, last at random; may break a request
  task automatic send_noise;
    logic [1:0] t;
    t = 2'($urandom_range(0, NUM_TYPES - 1));
    send(3'($urandom_range(0, 7)), t, pick_amount(t), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int phase_start;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: capacity 100, 0, top of range, 50; type 1 may overflow on check
    cap_plan[0] = 31'd100;
    cap_plan[1] = 31'd0;
    cap_plan[2] = 31'h7FFF_FFFF;
    cap_plan[3] = 31'd50;
    load_config(4'b0010);
    idle_odds = 5;
    send(ACT_CHECK,   2'd0, 32'd100,       1'b0);  // fits exactly
    send(ACT_CHECK,   2'd1, 32'h7FFF_FFFF, 1'b0);  // passes through the overflow bit
    send(ACT_CHECK,   2'd3, 32'd51,        1'b1);  // one over: request fails
    send(ACT_CHECK,   2'd0, 32'h8000_0000, 1'b1);  // most negative demand fits
    send(ACT_USE,     2'd0, 32'd100,       1'b0);
    send(ACT_USE,     2'd2, 32'h7FFF_FFFF, 1'b0);
    send(ACT_USE,     2'd3, 32'd60,        1'b1);  // over capacity
    send(ACT_USE,     2'd2, 32'd1,         1'b1);  // saturates at the top
    send(ACT_CHECK,   2'd0, 32'd1,         1'b1);  // full type rejects more
    send(ACT_RELEASE, 2'd0, 32'd150,       1'b1);  // clamps at zero, fails
    send(ACT_RELEASE, 2'd3, 32'h8000_0000, 1'b1);  // negative release grows usage
    send(ACT_ADJUST,  2'd3, 32'h8000_0000, 1'b0);  // clamps at zero
    send(ACT_ADJUST,  2'd2, 32'hFFFF_FFFF, 1'b1);
    send(ACT_SET,     2'd0, 32'hFFFF_FFFB, 1'b0);  // negative set reads as zero
    send(ACT_SET,     2'd1, 32'h7FFF_FFFF, 1'b1);
    send(3'd5,        2'd0, 32'd7,         1'b0);  // undefined actions do nothing
    send(3'd6,        2'd1, 32'd0,         1'b0);
    send(3'd7,        2'd3, 32'hFFFF_FFFF, 1'b1);
    send(ACT_SET,     2'd1, 32'd0,         1'b0);  // mixed request
    send(ACT_RELEASE, 2'd0, 32'd0,         1'b0);
    send(ACT_ADJUST,  2'd3, 32'd10,        1'b0);
    send(ACT_CHECK,   2'd2, 32'd0,         1'b1);

    // random phases, each with its own setting and idling; the last runs flat out
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: begin
          foreach (cap_plan[i]) cap_plan[i] = '0;
          load_config(4'hF);
          idle_odds = 6;
        end
        1: begin
          foreach (cap_plan[i]) cap_plan[i] = 31'h7FFF_FFFF;
          load_config(4'h0);
          idle_odds = 0;
        end
        2, 3, 5: begin
          foreach (cap_plan[i]) cap_plan[i] = 31'($urandom_range(0, 300));
          load_config(4'($urandom()));
          idle_odds = (p == 2) ? 4 : (p == 3) ? 10 : 3;
        end
        default: begin
          foreach (cap_plan[i]) cap_plan[i] = 31'($urandom());
          load_config(4'($urandom()));
          idle_odds = (p == NUM_PHASES - 1) ? 0 : 8;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_request();
        // in phase 3, hold off around mid-phase until the tracker has answered everything
        if (p == 3 && items_sent - phase_start >= PHASE_ITEMS / 2 &&
            items_sent - phase_start < PHASE_ITEMS / 2 + NUM_TYPES) begin
          drain();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("** multi_resource_usage_tracker_top: PASSED **");
    end else begin
      $display("** multi_resource_usage_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mrut_pkg.sv
rtl/core/mrut_ctrl.sv
rtl/core/mrut_datapath.sv
rtl/core/multi_resource_usage_tracker_top.sv
dv/mrut_usage_checker.sv
dv/tb_multi_resource_usage_tracker_top.sv
